@@ sv/rdh_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdh_pkg
// Shared types and constants of the rv32i decode and hazard detect block.
// ----------------------------------------------------------------------------
package rdh_pkg;

  localparam int COUNT_BITS  = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int TALLY_BITS  = 32;
  localparam int NUM_FORMATS = 6;

  localparam logic [6:0] OPC_OP     = 7'b0110011;
  localparam logic [6:0] OPC_OP_IMM = 7'b0010011;
  localparam logic [6:0] OPC_LOAD   = 7'b0000011;
  localparam logic [6:0] OPC_JALR   = 7'b1100111;
  localparam logic [6:0] OPC_SYSTEM = 7'b1110011;
  localparam logic [6:0] OPC_STORE  = 7'b0100011;
  localparam logic [6:0] OPC_BRANCH = 7'b1100011;
  localparam logic [6:0] OPC_JAL    = 7'b1101111;
  localparam logic [6:0] OPC_LUI    = 7'b0110111;
  localparam logic [6:0] OPC_AUIPC  = 7'b0010111;

  typedef enum logic [2:0] {
    FMT_R       = 3'd0,
    FMT_I       = 3'd1,
    FMT_S       = 3'd2,
    FMT_B       = 3'd3,
    FMT_U       = 3'd4,
    FMT_J       = 3'd5,
    FMT_UNKNOWN = 3'd6
  } format_e;

  // decoded item handed from the front end to the back end
  typedef struct packed {
    format_e     fmt;
    logic [4:0]  dest;
    logic [4:0]  src1;
    logic [4:0]  src2;
    logic [2:0]  funct3;
    logic [6:0]  funct7;
    logic [20:0] imm;
    logic        hazard_near;
    logic        hazard_far;
  } item_t;

  typedef struct packed {
    item_t                 item;
    logic [TALLY_BITS-1:0] tally;
  } result_t;

endpackage

@@ sv/rdh_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdh_front
// Classifies an instruction word, extracts its fields and checks it against
// the destinations of the two previous instructions.
// ----------------------------------------------------------------------------
module rdh_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [31:0]    instr_i,
  output rdh_pkg::item_t item_o
);

  logic [4:0] last_dest_q, last_dest_d;
  logic [4:0] older_dest_q, older_dest_d;

  rdh_pkg::format_e fmt;
  logic             use1, use2;
  rdh_pkg::item_t   item;

  always_comb begin
    unique case (instr_i[6:0])
      rdh_pkg::OPC_OP:     fmt = rdh_pkg::FMT_R;
      rdh_pkg::OPC_OP_IMM,
      rdh_pkg::OPC_LOAD,
      rdh_pkg::OPC_JALR,
      rdh_pkg::OPC_SYSTEM: fmt = rdh_pkg::FMT_I;
      rdh_pkg::OPC_STORE:  fmt = rdh_pkg::FMT_S;
      rdh_pkg::OPC_BRANCH: fmt = rdh_pkg::FMT_B;
      rdh_pkg::OPC_LUI,
      rdh_pkg::OPC_AUIPC:  fmt = rdh_pkg::FMT_U;
      rdh_pkg::OPC_JAL:    fmt = rdh_pkg::FMT_J;
      default:             fmt = rdh_pkg::FMT_UNKNOWN;
    endcase
  end

  always_comb begin
    item        = '0;
    item.fmt    = fmt;
    item.funct3 = instr_i[14:12];
    item.funct7 = instr_i[31:25];
    use1        = 1'b0;
    use2        = 1'b0;
    unique case (fmt)
      rdh_pkg::FMT_R: begin
        item.dest = instr_i[11:7];
        item.src1 = instr_i[19:15];
        item.src2 = instr_i[24:20];
        use1      = 1'b1;
        use2      = 1'b1;
      end
      rdh_pkg::FMT_I: begin
        item.dest = instr_i[11:7];
        item.src1 = instr_i[19:15];
        item.imm  = {9'd0, instr_i[31:20]};
        use1      = 1'b1;
      end
      rdh_pkg::FMT_S: begin
        item.src1 = instr_i[19:15];
        item.src2 = instr_i[24:20];
        item.imm  = {9'd0, instr_i[31:25], instr_i[11:7]};
        use1      = 1'b1;
        use2      = 1'b1;
      end
      rdh_pkg::FMT_B: begin
        item.src1 = instr_i[19:15];
        item.src2 = instr_i[24:20];
        item.imm  = {8'd0, instr_i[31], instr_i[7], instr_i[30:25], instr_i[11:8], 1'b0};
        use1      = 1'b1;
        use2      = 1'b1;
      end
      rdh_pkg::FMT_U: begin
        item.dest = instr_i[11:7];
        item.imm  = {1'b0, instr_i[31:12]};
      end
      rdh_pkg::FMT_J: begin
        item.dest = instr_i[11:7];
        item.imm  = {instr_i[31], instr_i[19:12], instr_i[20], instr_i[30:21], 1'b0};
      end
      default: begin
      end
    endcase
    // x0 never causes a hazard
    item.hazard_near = (last_dest_q != 5'd0) &&
                       ((use1 && item.src1 == last_dest_q) ||
                        (use2 && item.src2 == last_dest_q));
    item.hazard_far  = (older_dest_q != 5'd0) &&
                       ((use1 && item.src1 == older_dest_q) ||
                        (use2 && item.src2 == older_dest_q));
  end

  assign item_o = item;

  always_comb begin
    last_dest_d  = last_dest_q;
    older_dest_d = older_dest_q;
    if (accept_i) begin
      older_dest_d = last_dest_q;
      last_dest_d  = item.dest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_dest_q  <= 5'd0;
      older_dest_q <= 5'd0;
    end else begin
      last_dest_q  <= last_dest_d;
      older_dest_q <= older_dest_d;
    end
  end

endmodule

@@ sv/rdh_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdh_fifo
// Short queue of decoded items between the front end and the back end.
// ----------------------------------------------------------------------------
module rdh_fifo #(
  parameter int DEPTH = rdh_pkg::QUEUE_DEPTH
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rdh_pkg::item_t wdata_i,
  output logic           full_o,
  input  logic           pop_i,
  output rdh_pkg::item_t rdata_o,
  output logic           empty_o
);

  localparam int PtrBits = $clog2(DEPTH);
  localparam int CntBits = $clog2(DEPTH + 1);

  rdh_pkg::item_t     mem_q [DEPTH];
  logic [PtrBits-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CntBits-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == CntBits'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrBits'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrBits'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule

@@ sv/rdh_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdh_back
// Updates the per-format counts and holds the finished result for the
// output side.
// ----------------------------------------------------------------------------
module rdh_back #(
  parameter int COUNT_BITS = rdh_pkg::COUNT_BITS
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  rdh_pkg::item_t   q_item_i,
  output logic             q_pop_o,
  output logic             out_valid_o,
  input  logic             out_pop_i,
  output rdh_pkg::result_t out_o
);

  localparam int WideBits = (COUNT_BITS > rdh_pkg::TALLY_BITS) ? COUNT_BITS
                                                                : rdh_pkg::TALLY_BITS;

  logic [COUNT_BITS-1:0] counts_q [rdh_pkg::NUM_FORMATS];
  logic [COUNT_BITS-1:0] next_cnt;
  logic [WideBits-1:0]   wide_cnt;
  logic [2:0]            idx;
  logic                  known;
  logic                  take;
  logic                  out_valid_q, out_valid_d;
  rdh_pkg::result_t      out_q, out_d;

  assign take    = !q_empty_i && (!out_valid_q || out_pop_i);
  assign q_pop_o = take;
  assign idx     = q_item_i.fmt;
  assign known   = (q_item_i.fmt != rdh_pkg::FMT_UNKNOWN);

  always_comb begin
    next_cnt = '0;
    if (known) begin
      next_cnt = counts_q[idx] + 1'b1;
    end
  end

  assign wide_cnt = WideBits'(next_cnt);

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (take) begin
      out_d.item  = q_item_i;
      out_d.tally = wide_cnt[rdh_pkg::TALLY_BITS-1:0];
      out_valid_d = 1'b1;
    end else if (out_pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < rdh_pkg::NUM_FORMATS; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (take && known) begin
        counts_q[idx] <= next_cnt;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

@@ sv/rv32i_decode_hazard_detect.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_decode_hazard_detect
// RV32I decode with format classification, field extraction, read-after-
// write hazard flags at distance one and two, and per-format counts.
// ----------------------------------------------------------------------------
// channel   direction  handshake          payload
// input     in         push / full        instruction_word_i
// result    out        empty / pop        format_code_o .. format_tally_o
//
// one item per clock sustained while the result side keeps popping; a pushed
// item passes through the decoded-item queue, then the output register.
// reset clears the destination history, the counts and the queue at once.
// a stalled result side fills the queue, then full rises; the front end
// decodes in the cycle of acceptance and never stalls by itself.
// ----------------------------------------------------------------------------
module rv32i_decode_hazard_detect #(
  parameter int COUNT_BITS  = rdh_pkg::COUNT_BITS,
  parameter int QUEUE_DEPTH = rdh_pkg::QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [31:0] instruction_word_i,
  output logic        empty,
  input  logic        pop,
  output logic [2:0]  format_code_o,
  output logic [4:0]  dest_reg_o,
  output logic [4:0]  src_reg_one_o,
  output logic [4:0]  src_reg_two_o,
  output logic [2:0]  func_three_o,
  output logic [6:0]  func_seven_o,
  output logic [20:0] immediate_bits_o,
  output logic        hazard_near_o,
  output logic        hazard_far_o,
  output logic [31:0] format_tally_o
);

  rdh_pkg::item_t   dec_item, q_item;
  rdh_pkg::result_t res;
  logic             accept, q_full, q_empty, q_pop, out_valid;

  assign accept = push && !q_full;
  assign full   = q_full;

  rdh_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .instr_i  (instruction_word_i),
    .item_o   (dec_item)
  );

  rdh_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (dec_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_item),
    .empty_o (q_empty)
  );

  rdh_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid),
    .out_pop_i   (pop),
    .out_o       (res)
  );

  assign empty            = !out_valid;
  assign format_code_o    = res.item.fmt;
  assign dest_reg_o       = res.item.dest;
  assign src_reg_one_o    = res.item.src1;
  assign src_reg_two_o    = res.item.src2;
  assign func_three_o     = res.item.funct3;
  assign func_seven_o     = res.item.funct7;
  assign immediate_bits_o = res.item.imm;
  assign hazard_near_o    = res.item.hazard_near;
  assign hazard_far_o     = res.item.hazard_far;
  assign format_tally_o   = res.tally;

  // a full queue means the output register is holding a result
  assert property (@(posedge clk_i) disable iff (!rst_ni) q_full |-> out_valid)
    else $error("queue full while output register empty");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && format_code_o == rdh_pkg::FMT_UNKNOWN) |->
      (format_tally_o == '0 && dest_reg_o == '0 && immediate_bits_o == '0))
    else $error("unknown format carries count or fields");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && (format_code_o == rdh_pkg::FMT_U || format_code_o == rdh_pkg::FMT_J)) |->
      (!hazard_near_o && !hazard_far_o && format_tally_o != '0))
    else $error("u or j format flagged a hazard or has no count");

  // an accepted item with nothing ahead reaches the queue on the next edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && q_empty) |=> !q_empty)
    else $error("accepted item lost before the queue");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the rv32i decode and hazard detect block against a decode predictor.
// A directed run of edge-case instructions comes first, then bursts of random
// instructions with bursty input and a stalling output. Every result is
// compared field by field with the predicted decode, in order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int RANDOM_ITEMS    = 1800;
  localparam int LONG_HOLD       = 300;
  localparam int WATCHDOG_CYCLES = 3000;
  localparam int SETTLE_CYCLES   = 8;
  localparam int MAX_REPORTS     = 100;

  // predicts each decode and holds the ones not yet seen at the output
  class decode_scoreboard;
    logic [4:0]                    last_dest;
    logic [4:0]                    older_dest;
    logic [rdh_pkg::COUNT_BITS-1:0] format_counts [rdh_pkg::NUM_FORMATS];
    rdh_pkg::result_t              expected_decodes [$];
    int                            failures;

    function new();
      last_dest  = '0;
      older_dest = '0;
      foreach (format_counts[i]) format_counts[i] = '0;
      failures   = 0;
    endfunction

    function int pending();
      return expected_decodes.size();
    endfunction

    function void note_instruction(logic [31:0] w);
      rdh_pkg::result_t r;
      logic             use1;
      logic             use2;
      r    = '0;
      use1 = 1'b0;
      use2 = 1'b0;
      r.item.funct3 = w[14:12];
      r.item.funct7 = w[31:25];
      case (w[6:0])
        rdh_pkg::OPC_OP:     r.item.fmt = rdh_pkg::FMT_R;
        rdh_pkg::OPC_OP_IMM,
        rdh_pkg::OPC_LOAD,
        rdh_pkg::OPC_JALR,
        rdh_pkg::OPC_SYSTEM: r.item.fmt = rdh_pkg::FMT_I;
        rdh_pkg::OPC_STORE:  r.item.fmt = rdh_pkg::FMT_S;
        rdh_pkg::OPC_BRANCH: r.item.fmt = rdh_pkg::FMT_B;
        rdh_pkg::OPC_LUI,
        rdh_pkg::OPC_AUIPC:  r.item.fmt = rdh_pkg::FMT_U;
        rdh_pkg::OPC_JAL:    r.item.fmt = rdh_pkg::FMT_J;
        default:             r.item.fmt = rdh_pkg::FMT_UNKNOWN;
      endcase
      case (r.item.fmt)
        rdh_pkg::FMT_R: begin
          r.item.dest = w[11:7];
          r.item.src1 = w[19:15];
          r.item.src2 = w[24:20];
          use1 = 1'b1;
          use2 = 1'b1;
        end
        rdh_pkg::FMT_I: begin
          r.item.dest = w[11:7];
          r.item.src1 = w[19:15];
          r.item.imm  = {9'd0, w[31:20]};
          use1 = 1'b1;
        end
        rdh_pkg::FMT_S: begin
          r.item.src1 = w[19:15];
          r.item.src2 = w[24:20];
          r.item.imm  = {9'd0, w[31:25], w[11:7]};
          use1 = 1'b1;
          use2 = 1'b1;
        end
        rdh_pkg::FMT_B: begin
          r.item.src1 = w[19:15];
          r.item.src2 = w[24:20];
          r.item.imm  = {8'd0, w[31], w[7], w[30:25], w[11:8], 1'b0};
          use1 = 1'b1;
          use2 = 1'b1;
        end
        rdh_pkg::FMT_U: begin
          r.item.dest = w[11:7];
          r.item.imm  = {1'b0, w[31:12]};
        end
        rdh_pkg::FMT_J: begin
          r.item.dest = w[11:7];
          r.item.imm  = {w[31], w[19:12], w[20], w[30:21], 1'b0};
        end
        default: ;
      endcase
      // x0 never causes a hazard
      r.item.hazard_near = (last_dest != 0) &&
                           ((use1 && r.item.src1 == last_dest) ||
                            (use2 && r.item.src2 == last_dest));
      r.item.hazard_far  = (older_dest != 0) &&
                           ((use1 && r.item.src1 == older_dest) ||
                            (use2 && r.item.src2 == older_dest));
      if (r.item.fmt != rdh_pkg::FMT_UNKNOWN) begin
        format_counts[r.item.fmt] = format_counts[r.item.fmt] + 1'b1;
        r.tally = format_counts[r.item.fmt];
      end
      older_dest = last_dest;
      last_dest  = r.item.dest;
      expected_decodes.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h",
                   $time, name, want, got);
      end
    endfunction

    function void check_decode(logic [2:0] fmt, logic [4:0] dest, logic [4:0] src1,
                               logic [4:0] src2, logic [2:0] funct3,
                               logic [6:0] funct7, logic [20:0] imm, logic near,
                               logic far, logic [31:0] tally);
      rdh_pkg::result_t want;
      if (expected_decodes.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t ns: result with none expected, expected nothing, actual fmt %0d",
                   $time, fmt);
        return;
      end
      want = expected_decodes.pop_front();
      compare_field("format_code", 32'(want.item.fmt), 32'(fmt));
      compare_field("dest_reg", 32'(want.item.dest), 32'(dest));
      compare_field("src_reg_one", 32'(want.item.src1), 32'(src1));
      compare_field("src_reg_two", 32'(want.item.src2), 32'(src2));
      compare_field("func_three", 32'(want.item.funct3), 32'(funct3));
      compare_field("func_seven", 32'(want.item.funct7), 32'(funct7));
      compare_field("immediate_bits", 32'(want.item.imm), 32'(imm));
      compare_field("hazard_near", 32'(want.item.hazard_near), 32'(near));
      compare_field("hazard_far", 32'(want.item.hazard_far), 32'(far));
      compare_field("format_tally", 32'(want.tally), tally);
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        push       = 1'b0;
  logic        pop        = 1'b0;
  logic [31:0] instr_word = '0;
  logic        full;
  logic        empty;
  logic [2:0]  format_code;
  logic [4:0]  dest_reg;
  logic [4:0]  src_reg_one;
  logic [4:0]  src_reg_two;
  logic [2:0]  func_three;
  logic [6:0]  func_seven;
  logic [20:0] immediate_bits;
  logic        hazard_near;
  logic        hazard_far;
  logic [31:0] format_tally;

  bit long_hold_req = 1'b0;
  int idle_cycles   = 0;

  decode_scoreboard decode_check = new();

  always #6 clk = ~clk;

  rv32i_decode_hazard_detect i_dut (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .push               (push),
    .full               (full),
    .instruction_word_i (instr_word),
    .empty              (empty),
    .pop                (pop),
    .format_code_o      (format_code),
    .dest_reg_o         (dest_reg),
    .src_reg_one_o      (src_reg_one),
    .src_reg_two_o      (src_reg_two),
    .func_three_o       (func_three),
    .func_seven_o       (func_seven),
    .immediate_bits_o   (immediate_bits),
    .hazard_near_o      (hazard_near),
    .hazard_far_o       (hazard_far),
    .format_tally_o     (format_tally)
  );

  // handshakes are sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) decode_check.note_instruction(instr_word);
      if (pop && !empty)
        decode_check.check_decode(format_code, dest_reg, src_reg_one, src_reg_two,
                                  func_three, func_seven, immediate_bits,
                                  hazard_near, hazard_far, format_tally);
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_CYCLES) begin
        $display("%0t ns: no handshake for %0d cycles", $time, idle_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // offer one item and hold it until it is taken; returns at a falling edge
  task automatic send_instruction(input logic [31:0] word);
    push       = 1'b1;
    instr_word = word;
    do @(posedge clk); while (full);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    while (decode_check.pending() != 0) @(negedge clk);
  endtask

  // mostly real opcodes with few registers in play, so hazards are common
  function automatic logic [31:0] random_instruction();
    logic [31:0] w;
    w = $urandom;
    if ($urandom_range(0, 9) != 0) begin
      case ($urandom_range(0, 9))
        0:       w[6:0] = rdh_pkg::OPC_OP;
        1:       w[6:0] = rdh_pkg::OPC_OP_IMM;
        2:       w[6:0] = rdh_pkg::OPC_LOAD;
        3:       w[6:0] = rdh_pkg::OPC_JALR;
        4:       w[6:0] = rdh_pkg::OPC_SYSTEM;
        5:       w[6:0] = rdh_pkg::OPC_STORE;
        6:       w[6:0] = rdh_pkg::OPC_BRANCH;
        7:       w[6:0] = rdh_pkg::OPC_JAL;
        8:       w[6:0] = rdh_pkg::OPC_LUI;
        default: w[6:0] = rdh_pkg::OPC_AUIPC;
      endcase
      if ($urandom_range(0, 3) != 0) begin
        w[11:7]  = 5'($urandom_range(0, 3));
        w[19:15] = 5'($urandom_range(0, 3));
        w[24:20] = 5'($urandom_range(0, 3));
      end
    end
    return w;
  endfunction

  // output side: stall pattern that changes mode now and then
  initial begin
    int mode;
    int mode_left;
    int hold_left;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        hold_left     = LONG_HOLD;
        long_hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(20, 200);
        end
        mode_left--;
        case (mode)
          0:       pop = 1'b1;
          1:       pop = 1'($urandom_range(0, 1));
          default: pop = ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin
    logic [31:0] directed_words [$];
    int          sent;
    int          burst;
    int          gap;
    bit          hold_done;
    bit          drain_done;

    directed_words = '{
      32'h0000_0000,
      32'hFFFF_FFFF,
      {25'h1FF_FFFF, rdh_pkg::OPC_OP},
      {25'h1FF_FFFF, rdh_pkg::OPC_OP_IMM},
      {25'h1FF_FFFF, rdh_pkg::OPC_LOAD},
      {25'h1FF_FFFF, rdh_pkg::OPC_JALR},
      {25'h1FF_FFFF, rdh_pkg::OPC_SYSTEM},
      {25'h1FF_FFFF, rdh_pkg::OPC_STORE},
      {25'h1FF_FFFF, rdh_pkg::OPC_BRANCH},
      {25'h1FF_FFFF, rdh_pkg::OPC_JAL},
      {25'h1FF_FFFF, rdh_pkg::OPC_LUI},
      {25'h1FF_FFFF, rdh_pkg::OPC_AUIPC},
      {12'hABC, 5'd0, 3'd0, 5'd5, rdh_pkg::OPC_OP_IMM},       // addi x5
      {7'h20, 5'd5, 5'd5, 3'd0, 5'd7, rdh_pkg::OPC_OP},       // x5 one back
      {7'h55, 5'd5, 5'd7, 3'd2, 5'h0A, rdh_pkg::OPC_STORE},   // x7 one back, x5 two back
      {7'h2A, 5'd0, 5'd0, 3'd1, 5'h15, rdh_pkg::OPC_BRANCH},  // x0 only
      {20'h8_0001, 5'd9, rdh_pkg::OPC_LUI},
      {20'h7_FFFF, 5'd0, rdh_pkg::OPC_JAL},                   // jal x0
      {12'h004, 5'd9, 3'd2, 5'd1, rdh_pkg::OPC_LOAD},         // x9 two back
      {12'h000, 5'd1, 3'd0, 5'd0, rdh_pkg::OPC_JALR},         // x1 one back
      32'h0000_0073,                                          // ecall
      {7'h7F, 5'd1, 5'd1, 3'd7, 5'd3, 7'b0001011},            // unknown keeps x0 in history
      {7'h00, 5'd3, 5'd3, 3'd0, 5'd4, rdh_pkg::OPC_OP},
      {12'hFFF, 5'd4, 3'd0, 5'd4, rdh_pkg::OPC_SYSTEM},       // system reads rs1
      {12'h000, 5'd4, 3'd0, 5'd4, rdh_pkg::OPC_AUIPC}         // u format reads nothing
    };
    hold_done  = 1'b0;
    drain_done = 1'b0;

    repeat (4) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_words[i]) send_instruction(directed_words[i]);
    push = 1'b0;
    wait_for_results();

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      if (sent >= 600 && !hold_done) begin
        // output held off while input keeps coming, so the block backs up
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
        repeat (40) send_instruction(random_instruction());
        sent += 40;
      end else if (sent >= 1200 && !drain_done) begin
        push = 1'b0;
        wait_for_results();
        drain_done = 1'b1;
      end
      burst = $urandom_range(1, 40);
      repeat (burst) send_instruction(random_instruction());
      sent += burst;
      if ($urandom_range(0, 3) != 0) begin
        gap  = $urandom_range(1, 8);
        push = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    push = 1'b0;

    wait_for_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (decode_check.failures == 0 && decode_check.pending() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
